FILE: design/tlv_pkg.sv
// Shared types and constants for the timecode lock validator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package tlv_pkg;

  localparam int FRAME_W  = 23;
  localparam int SECS_W   = 17;
  localparam int MINS_W   = 11;
  localparam int ADJ_W    = 12;
  localparam int RUN_W    = 8;
  localparam int FSG_W    = 16;

  localparam int HOUR_SECS      = 3600;
  localparam int MIN_SECS       = 60;
  localparam int HOUR_MINS      = 60;
  // floor(x / 10) == (x * 6554) >> 16 for every minute count below 2048.
  localparam int TEN_RECIP       = 6554;
  localparam int TEN_RECIP_SHIFT = 16;
  localparam int RECIP_W         = 24;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam logic [7:0]  CONFIRM_RESET = 8'd3;
  localparam logic [15:0] DROPOUT_RESET = 16'd10;

  typedef enum logic [1:0] {
    CFG_CONFIRM_WINDOW = 2'd0,
    CFG_DROPOUT_LIMIT  = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] frame_in_second;
    logic       drop_frame;
    logic [2:0] rate_code;
    logic [5:0] nominal_fps;
  } in_item_t;

  typedef struct packed {
    logic locked;
    logic dropout;
  } out_item_t;

  // What the front hands to the back through the queue.
  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [2:0]         rate_code;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]  confirm_window;
    logic [15:0] dropout_limit;
  } cfg_t;

endpackage

FILE: design/timecode_lock_validator_top.sv
// Top level of the timecode lock validator: configuration registers and wiring.
// Depends on tlv_pkg, tlv_front, tlv_queue and tlv_back.
`timescale 1ns / 1ps
// One timecode item in, one result item (locked, dropout) out, in order. The
// block accepts an item every cycle while results are taken; each item passes
// through the frame-number pipeline (one constant multiply stage, one fps
// multiply stage), the four-entry queue and the output register. Input stall
// rises only when queue entries plus items in the pipeline reach the queue
// depth. Configuration writes are always accepted and should only be made
// while the block is idle.
module timecode_lock_validator_top
  import tlv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t               cfg_r;
  logic               push, pop, q_valid;
  frame_item_t        push_data, q_data;
  logic [Q_CNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_window <= CONFIRM_RESET;
      cfg_r.dropout_limit  <= DROPOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONFIRM_WINDOW: cfg_r.confirm_window <= cfg_data[7:0];
        CFG_DROPOUT_LIMIT:  cfg_r.dropout_limit  <= cfg_data;
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  tlv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  tlv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  tlv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/tlv_front.sv
// Front end: two-stage pipeline that turns a timecode into a linear frame number.
// Depends on tlv_pkg; pushes into tlv_queue and throttles on its fill count.
`timescale 1ns / 1ps
module tlv_front
  import tlv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  input  logic [Q_CNT_W-1:0] q_count,
  output logic               push,
  output frame_item_t        push_data
);

  logic               v1_r, v2_r;
  logic [SECS_W-1:0]  secs_r;
  logic [5:0]         fps_r, fis_r;
  logic [ADJ_W-1:0]   adj_r;
  logic [2:0]         rate1_r;
  logic [FRAME_W-1:0] n2_r;
  logic [2:0]         rate2_r;

  logic [SECS_W-1:0]  secs_nxt;
  logic [MINS_W-1:0]  mins;
  logic [RECIP_W-1:0] recip_prod;
  logic [MINS_W-1:0]  tens;
  logic [ADJ_W-1:0]   adj_nxt;
  logic [FRAME_W-1:0] prod;
  logic [FRAME_W-1:0] n2_nxt;
  logic               take;

  // Items in flight in the pipeline already hold a queue slot.
  assign in_stall = ({1'b0, q_count} + {{Q_CNT_W{1'b0}}, v1_r} + {{Q_CNT_W{1'b0}}, v2_r})
                    >= (Q_CNT_W+1)'(Q_DEPTH);
  assign take = in_valid && !in_stall;

  always_comb begin
    secs_nxt = SECS_W'(in_data.hours) * SECS_W'(HOUR_SECS)
             + SECS_W'(in_data.minutes) * SECS_W'(MIN_SECS)
             + SECS_W'(in_data.seconds);
    mins = MINS_W'(in_data.hours) * MINS_W'(HOUR_MINS) + MINS_W'(in_data.minutes);
    recip_prod = RECIP_W'(mins) * RECIP_W'(TEN_RECIP);
    tens = MINS_W'(recip_prod >> TEN_RECIP_SHIFT);
    // Drop-frame skips two frames each minute except every tenth one.
    adj_nxt = in_data.drop_frame ? ADJ_W'({mins - tens, 1'b0}) : '0;
  end

  always_comb begin
    prod = FRAME_W'(secs_r) * FRAME_W'(fps_r);
    n2_nxt = prod + FRAME_W'(fis_r) - FRAME_W'(adj_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      secs_r  <= secs_nxt;
      fps_r   <= in_data.nominal_fps;
      fis_r   <= in_data.frame_in_second;
      adj_r   <= adj_nxt;
      rate1_r <= in_data.rate_code;
    end
    if (v1_r) begin
      n2_r    <= n2_nxt;
      rate2_r <= rate1_r;
    end
  end

  assign push = v2_r;
  assign push_data.frame_number = n2_r;
  assign push_data.rate_code    = rate2_r;

endmodule

FILE: design/tlv_queue.sv
// Small FIFO of frame numbers between the front and back halves.
// Depends on tlv_pkg for the item type and depth.
`timescale 1ns / 1ps
module tlv_queue
  import tlv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  frame_item_t        push_data,
  input  logic               pop,
  output logic               q_valid,
  output frame_item_t        q_data,
  output logic [Q_CNT_W-1:0] q_count
);

  frame_item_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign q_valid = cnt_r != '0;
  assign q_data  = mem_r[rd_r];
  assign q_count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

FILE: design/tlv_back.sv
// Back end: continuity check, lock and dropout tracking, output register.
// Depends on tlv_pkg; drains tlv_queue.
`timescale 1ns / 1ps
module tlv_back
  import tlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  frame_item_t q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic               have_r, have_nxt;
  logic [2:0]         prate_r;
  logic [FRAME_W-1:0] pframe_r;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic               lock_r, lock_nxt;
  logic [FSG_W-1:0]   fsg_r, fsg_nxt;
  logic               ovalid_r;
  out_item_t          odata_r, odata_nxt;

  assign pop = q_valid && (!ovalid_r || !out_stall);

  always_comb begin
    have_nxt  = 1'b1;
    run_nxt   = run_r;
    lock_nxt  = lock_r;
    fsg_nxt   = (fsg_r == '1) ? fsg_r : fsg_r + 1'b1;
    odata_nxt.locked = 1'b0;
    if (!have_r) begin
      run_nxt = RUN_W'(1);
    end else if (q_data.rate_code != prate_r ||
                 q_data.frame_number != pframe_r + 1'b1) begin
      run_nxt  = RUN_W'(1);
      lock_nxt = 1'b0;
    end else begin
      run_nxt = (run_r == '1) ? run_r : run_r + 1'b1;
      fsg_nxt = '0;
      if (run_nxt >= cfg.confirm_window) lock_nxt = 1'b1;
      odata_nxt.locked = lock_nxt;
    end
    odata_nxt.dropout = fsg_nxt >= cfg.dropout_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      prate_r  <= '0;
      pframe_r <= '0;
      run_r    <= '0;
      lock_r   <= 1'b0;
      fsg_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (pop) begin
        have_r   <= have_nxt;
        prate_r  <= q_data.rate_code;
        pframe_r <= q_data.frame_number;
        run_r    <= run_nxt;
        lock_r   <= lock_nxt;
        fsg_r    <= fsg_nxt;
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule
